// ----- hdl/radius_attribute_parser_macros.svh -----
`ifndef RADIUS_ATTRIBUTE_PARSER_MACROS_SVH
`define RADIUS_ATTRIBUTE_PARSER_MACROS_SVH

// Concurrent checks; the enclosing module provides clk and rst_n.

// Property holds on every clock edge out of reset.
`define RAP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define RAP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RAP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/rap_pkg.sv -----
package rap_pkg;

  // Message codes accepted by the header check
  localparam logic [7:0] CODE_ACCESS_REQ  = 8'd1;
  localparam logic [7:0] CODE_ACCT_RESP   = 8'd5;
  localparam logic [7:0] CODE_ACCESS_CHAL = 8'd11;

  // Attribute types with special handling
  localparam logic [7:0] ATTR_NAS_PORT    = 8'd5;
  localparam logic [7:0] ATTR_ACCT_STATUS = 8'd40;

  // Parse status codes
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_SHORT_HEADER = 3'd1;
  localparam logic [2:0] ST_UNKNOWN_CODE = 3'd2;
  localparam logic [2:0] ST_TRUNCATED    = 3'd3;
  localparam logic [2:0] ST_LEN_BELOW_2  = 3'd4;

  // Result kinds
  localparam logic RK_ATTR    = 1'b0;
  localparam logic RK_SUMMARY = 1'b1;

  localparam logic [15:0] HDR_LAST_POS = 16'd19;
  localparam logic [7:0]  ATTR_HDR_LEN = 8'd2;

  localparam int OUT_TDATA_W = 136;

  typedef struct packed {
    logic        kind;
    logic        last;
    logic [7:0]  attr_type;
    logic [7:0]  value_length;
    logic        first_of_type;
    logic [31:0] value_word;
    logic [7:0]  msg_code;
    logic [7:0]  msg_ident;
    logic [31:0] acct_status;
    logic [31:0] nas_port_value;
    logic [2:0]  parse_status;
    logic        length_exceeds;
  } rap_result_t;

  // Up to two results pushed per accepted byte
  typedef struct packed {
    logic [1:0]  cnt;
    rap_result_t e0;
    rap_result_t e1;
  } rap_push_t;

endpackage

// ----- hdl/rap_front.sv -----
module rap_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc_en,
  input  logic [7:0]       byte_i,
  input  logic             end_i,
  output rap_pkg::rap_push_t push_o
);
  import rap_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_TYPE,
    PH_LEN,
    PH_VALUE,
    PH_STOP
  } phase_t;

  phase_t       phase_r, phase_nxt;
  logic [15:0]  pos_r, pos_nxt;
  logic [255:0] seen_r, seen_nxt;
  logic [7:0]   cur_type_r, cur_type_nxt;
  logic [7:0]   left_r, left_nxt;
  logic [7:0]   vlen_r, vlen_nxt;
  logic [2:0]   vidx_r, vidx_nxt;
  logic [31:0]  acc_r, acc_nxt;
  logic [7:0]   code_r, code_nxt;
  logic [7:0]   ident_r, ident_nxt;
  logic [15:0]  hlen_r, hlen_nxt;
  logic [31:0]  acct_r, acct_nxt;
  logic [31:0]  nas_r, nas_nxt;
  logic [2:0]   err_r, err_nxt;

  logic         rep;
  logic         rep_first;
  logic         short_hdr;
  rap_result_t  rep_e, sum_e;

  function automatic logic code_ok(input logic [7:0] c);
    return ((c >= CODE_ACCESS_REQ) && (c <= CODE_ACCT_RESP)) || (c == CODE_ACCESS_CHAL);
  endfunction

  always_comb begin
    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    seen_nxt     = seen_r;
    cur_type_nxt = cur_type_r;
    left_nxt     = left_r;
    vlen_nxt     = vlen_r;
    vidx_nxt     = vidx_r;
    acc_nxt      = acc_r;
    code_nxt     = code_r;
    ident_nxt    = ident_r;
    hlen_nxt     = hlen_r;
    acct_nxt     = acct_r;
    nas_nxt      = nas_r;
    err_nxt      = err_r;
    rep          = 1'b0;
    rep_first    = ~seen_r[cur_type_r];
    short_hdr    = 1'b0;
    rep_e        = '0;
    sum_e        = '0;
    push_o       = '0;

    if (acc_en) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (pos_r == 16'd0) begin
            code_nxt = byte_i;
          end else if (pos_r == 16'd1) begin
            ident_nxt = byte_i;
          end else if (pos_r == 16'd2) begin
            hlen_nxt = {byte_i, 8'd0};
          end else if (pos_r == 16'd3) begin
            hlen_nxt = {hlen_r[15:8], byte_i};
          end
          if (pos_r == HDR_LAST_POS) begin
            if (code_ok(code_r)) begin
              phase_nxt = PH_TYPE;
            end else begin
              err_nxt   = ST_UNKNOWN_CODE;
              phase_nxt = PH_STOP;
            end
          end
        end
        PH_TYPE: begin
          cur_type_nxt = byte_i;
          phase_nxt    = PH_LEN;
        end
        PH_LEN: begin
          if (byte_i < ATTR_HDR_LEN) begin
            err_nxt   = ST_LEN_BELOW_2;
            phase_nxt = PH_STOP;
          end else begin
            vlen_nxt = byte_i - ATTR_HDR_LEN;
            left_nxt = byte_i - ATTR_HDR_LEN;
            vidx_nxt = 3'd0;
            acc_nxt  = '0;
            if (byte_i == ATTR_HDR_LEN) begin
              rep       = 1'b1;
              phase_nxt = PH_TYPE;
            end else begin
              phase_nxt = PH_VALUE;
            end
          end
        end
        PH_VALUE: begin
          // first four value bytes land big-endian
          if (!vidx_r[2]) begin
            unique case (vidx_r[1:0])
              2'd0: acc_nxt[31:24] = acc_r[31:24] | byte_i;
              2'd1: acc_nxt[23:16] = acc_r[23:16] | byte_i;
              2'd2: acc_nxt[15:8]  = acc_r[15:8]  | byte_i;
              default: acc_nxt[7:0] = acc_r[7:0] | byte_i;
            endcase
            vidx_nxt = vidx_r + 3'd1;
          end
          left_nxt = left_r - 8'd1;
          if (left_r == 8'd1) begin
            rep       = 1'b1;
            phase_nxt = PH_TYPE;
          end
        end
        default: phase_nxt = PH_STOP;
      endcase

      if (rep) begin
        seen_nxt[cur_type_r] = 1'b1;
        if (cur_type_r == ATTR_ACCT_STATUS) begin
          acct_nxt = acc_nxt;
        end
        if ((cur_type_r == ATTR_NAS_PORT) && rep_first) begin
          nas_nxt = acc_nxt;
        end
        rep_e.kind          = RK_ATTR;
        rep_e.last          = ~end_i;
        rep_e.attr_type     = cur_type_r;
        rep_e.value_length  = vlen_nxt;
        rep_e.first_of_type = rep_first;
        rep_e.value_word    = acc_nxt;
      end

      if (pos_r != 16'hFFFF) begin
        pos_nxt = pos_r + 16'd1;
      end

      if (end_i) begin
        short_hdr = (phase_nxt == PH_HEADER);
        if (short_hdr) begin
          err_nxt = ST_SHORT_HEADER;
        end else if (((phase_nxt == PH_LEN) || (phase_nxt == PH_VALUE)) &&
                     (err_nxt == ST_OK)) begin
          err_nxt = ST_TRUNCATED;
        end
        sum_e.kind           = RK_SUMMARY;
        sum_e.last           = 1'b1;
        sum_e.msg_code       = code_nxt;
        sum_e.msg_ident      = ident_nxt;
        sum_e.acct_status    = acct_nxt;
        sum_e.nas_port_value = nas_nxt;
        sum_e.parse_status   = err_nxt;
        sum_e.length_exceeds = ~short_hdr && (hlen_nxt > pos_nxt);

        // per-packet state back to its start values
        phase_nxt    = PH_HEADER;
        pos_nxt      = '0;
        seen_nxt     = '0;
        cur_type_nxt = '0;
        left_nxt     = '0;
        vlen_nxt     = '0;
        vidx_nxt     = '0;
        acc_nxt      = '0;
        code_nxt     = '0;
        ident_nxt    = '0;
        hlen_nxt     = '0;
        acct_nxt     = '0;
        nas_nxt      = '0;
        err_nxt      = ST_OK;
      end

      push_o.cnt = {1'b0, rep} + {1'b0, end_i};
      push_o.e0  = rep ? rep_e : sum_e;
      push_o.e1  = sum_e;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      pos_r      <= '0;
      seen_r     <= '0;
      cur_type_r <= '0;
      left_r     <= '0;
      vlen_r     <= '0;
      vidx_r     <= '0;
      acc_r      <= '0;
      code_r     <= '0;
      ident_r    <= '0;
      hlen_r     <= '0;
      acct_r     <= '0;
      nas_r      <= '0;
      err_r      <= ST_OK;
    end else begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      seen_r     <= seen_nxt;
      cur_type_r <= cur_type_nxt;
      left_r     <= left_nxt;
      vlen_r     <= vlen_nxt;
      vidx_r     <= vidx_nxt;
      acc_r      <= acc_nxt;
      code_r     <= code_nxt;
      ident_r    <= ident_nxt;
      hlen_r     <= hlen_nxt;
      acct_r     <= acct_nxt;
      nas_r      <= nas_nxt;
      err_r      <= err_nxt;
    end
  end

endmodule

// ----- hdl/rap_queue.sv -----
`include "radius_attribute_parser_macros.svh"

module rap_queue #(
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rap_pkg::rap_push_t   push,
  input  logic                 pop,
  output logic                 space2,
  output logic                 head_valid,
  output rap_pkg::rap_result_t head
);
  import rap_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  rap_result_t    mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt, wr_ptr1;
  logic [CW-1:0]  count_r, count_nxt;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wr_ptr1    = ptr_inc(wr_ptr_r);
  assign space2     = (count_r <= CW'(DEPTH - 2));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push.cnt == 2'd1) begin
      wr_ptr_nxt = wr_ptr1;
    end else if (push.cnt == 2'd2) begin
      wr_ptr_nxt = ptr_inc(wr_ptr1);
    end
    if (pop) begin
      rd_ptr_nxt = ptr_inc(rd_ptr_r);
    end
    count_nxt = count_r + CW'(push.cnt) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.e0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr1] <= push.e1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `RAP_ASSERT(a_count_bound, count_r <= CW'(DEPTH), "queue count above depth")
  `RAP_ASSERT_IMP(a_no_overflow, push.cnt != 2'd0, count_r <= CW'(DEPTH) - CW'(push.cnt), "queue overflow")
  `RAP_ASSERT_IMP(a_no_underflow, pop, count_r != '0, "pop from empty queue")
  `RAP_ASSERT_NEXT(a_pop_drains, pop && (push.cnt == 2'd0), count_r == $past(count_r) - 1'b1, "pop did not drain")

endmodule

// ----- hdl/rap_back.sv -----
module rap_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              head_valid,
  input  rap_pkg::rap_result_t              head,
  output logic                              pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rap_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                              out_tuser,
  output logic                              out_tlast
);
  import rap_pkg::*;

  logic        out_valid_r, out_valid_nxt;
  rap_result_t res_r;

  assign pop = head_valid && (!out_valid_r || out_tready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= head;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.kind;
  assign out_tlast  = res_r.last;
  assign out_tdata  = {3'b000,
                       res_r.length_exceeds,
                       res_r.parse_status,
                       res_r.nas_port_value,
                       res_r.acct_status,
                       res_r.msg_ident,
                       res_r.msg_code,
                       res_r.value_word,
                       res_r.first_of_type,
                       res_r.value_length,
                       res_r.attr_type};

endmodule

// ----- hdl/radius_attribute_parser.sv -----
// Channel   Dir  Beat contents
// in_*      in   tdata[7:0] payload_byte, tlast end_of_payload
// out_*     out  tdata parsed fields (see port), tuser result_kind, tlast last_result
//
// Cycles: one payload byte per clock while out_tready stays high; an
//   end-of-payload byte adds a second beat, so runs of very short packets
//   can hold the input below one byte per clock. A result passes through
//   the result queue and then the output register.
// Throughput is set by the parser register update, one byte per edge while in_tready is high.
// in_tready drops only while the result queue has fewer than two free slots.
// Reset (rst_n low, synchronous) clears parser state, the seen-type map and
//   the queue; the map also clears itself on every end-of-payload byte.
// A stalled out_tready holds the output register; the queue keeps absorbing.
module radius_attribute_parser #(
  parameter int QUEUE_DEPTH = 4  // result queue entries, at least 2
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input byte stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] payload_byte
  input  logic                            in_tlast,   // end_of_payload
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [7:0] attr_type, [15:8] value_length, [16] first_of_type,
  // [48:17] value_word, [56:49] msg_code, [64:57] msg_ident,
  // [96:65] acct_status, [128:97] nas_port_value, [131:129] parse_status,
  // [132] length_exceeds_payload, [135:133] zero
  output logic [rap_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tuser,  // result_kind
  output logic                            out_tlast   // last_result
);
  import rap_pkg::*;

  rap_push_t   push;
  rap_result_t head;
  logic        space2;
  logic        head_valid;
  logic        pop;
  logic        acc_en;

  // A byte is taken only when the queue can hold both results it may cause
  // (an attribute report plus the packet summary).
  assign in_tready = space2;
  assign acc_en    = in_tvalid && in_tready;

  // Front: header check, TLV walk, seen map, summary build
  rap_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .acc_en (acc_en),
    .byte_i (in_tdata),
    .end_i  (in_tlast),
    .push_o (push)
  );

  // Decoupling queue, up to two writes and one read per cycle
  rap_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (pop),
    .space2     (space2),
    .head_valid (head_valid),
    .head       (head)
  );

  // Back: output register and beat packing
  rap_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- test/radius_result_checker.sv -----
`timescale 1ns / 1ps

// Watches both streams of the parser, predicts the result beats of every accepted
// payload byte and compares them in order against what leaves the block.
module radius_result_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [7:0]                      in_tdata,
  input  logic                            in_tlast,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [rap_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            out_tuser,
  input  logic                            out_tlast,
  output int                              fail_count,
  output int                              pending_count
);
  import rap_pkg::*;

  typedef enum logic [2:0] {HDR, ATTR_TYPE, ATTR_LEN, ATTR_VALUE, HALTED} phase_t;

  // per-packet parser state
  logic [15:0]  pos;
  phase_t       phase;
  logic [255:0] seen_map;
  logic [7:0]   cur_type;
  logic [7:0]   value_left;
  logic [7:0]   value_len;
  logic [31:0]  value_acc;
  logic [7:0]   hdr_code;
  logic [7:0]   hdr_ident;
  logic [15:0]  hdr_len;
  logic [31:0]  acct_last;
  logic [31:0]  nas_first;
  logic [2:0]   status;

  rap_result_t parsed_results_q[$];
  int mismatches = 0;
  int backlog = 0;

  assign fail_count    = mismatches;
  assign pending_count = backlog;

  function automatic void clear_packet_state();
    pos        = '0;
    phase      = HDR;
    seen_map   = '0;
    cur_type   = '0;
    value_left = '0;
    value_len  = '0;
    value_acc  = '0;
    hdr_code   = '0;
    hdr_ident  = '0;
    hdr_len    = '0;
    acct_last  = '0;
    nas_first  = '0;
    status     = ST_OK;
  endfunction

  function automatic rap_result_t attr_report();
    rap_result_t r;
    r               = '0;
    r.kind          = RK_ATTR;
    r.attr_type     = cur_type;
    r.value_length  = value_len;
    r.first_of_type = !seen_map[cur_type];
    r.value_word    = value_acc;
    seen_map[cur_type] = 1'b1;
    if (cur_type == ATTR_ACCT_STATUS) acct_last = value_acc;
    if (cur_type == ATTR_NAS_PORT && r.first_of_type) nas_first = value_acc;
    return r;
  endfunction

  task automatic parse_payload_byte(input logic [7:0] b, input logic eop);
    rap_result_t res[2];
    int          n;
    int          idx;
    logic        short_hdr;
    n = 0;
    case (phase)
      HDR: begin
        case (pos)
          16'd0: hdr_code = b;
          16'd1: hdr_ident = b;
          16'd2: hdr_len[15:8] = b;
          16'd3: hdr_len[7:0] = b;
          default: ;
        endcase
        if (pos == HDR_LAST_POS) begin
          if ((hdr_code >= CODE_ACCESS_REQ && hdr_code <= CODE_ACCT_RESP)
              || hdr_code == CODE_ACCESS_CHAL) begin
            phase = ATTR_TYPE;
          end else begin
            status = ST_UNKNOWN_CODE;
            phase  = HALTED;
          end
        end
      end
      ATTR_TYPE: begin
        cur_type = b;
        phase    = ATTR_LEN;
      end
      ATTR_LEN: begin
        if (b < ATTR_HDR_LEN) begin
          status = ST_LEN_BELOW_2;
          phase  = HALTED;
        end else begin
          value_len  = b - ATTR_HDR_LEN;
          value_left = value_len;
          value_acc  = '0;
          if (value_left == 0) begin
            res[n] = attr_report();
            n++;
            phase = ATTR_TYPE;
          end else begin
            phase = ATTR_VALUE;
          end
        end
      end
      ATTR_VALUE: begin
        idx = int'(value_len) - int'(value_left);
        if (idx < 4) value_acc[31 - 8 * idx -: 8] = b;
        value_left = value_left - 8'd1;
        if (value_left == 0) begin
          res[n] = attr_report();
          n++;
          phase = ATTR_TYPE;
        end
      end
      default: phase = HALTED;
    endcase

    if (pos != 16'hFFFF) pos = pos + 16'd1;

    if (eop) begin
      short_hdr = (phase == HDR);
      if (short_hdr) status = ST_SHORT_HEADER;
      else if ((phase == ATTR_LEN || phase == ATTR_VALUE) && status == ST_OK)
        status = ST_TRUNCATED;
      res[n]                = '0;
      res[n].kind           = RK_SUMMARY;
      res[n].msg_code       = hdr_code;
      res[n].msg_ident      = hdr_ident;
      res[n].acct_status    = acct_last;
      res[n].nas_port_value = nas_first;
      res[n].parse_status   = status;
      res[n].length_exceeds = !short_hdr && (hdr_len > pos);
      n++;
      clear_packet_state();
    end

    if (n > 0) res[n - 1].last = 1'b1;
    for (int i = 0; i < n; i++) parsed_results_q.push_back(res[i]);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      if (mismatches < 10)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    rap_result_t want;
    rap_result_t got;
    if (!rst_n) begin
      clear_packet_state();
      parsed_results_q.delete();
    end else begin
      if (in_tvalid && in_tready) parse_payload_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        got                = '0;
        got.kind           = out_tuser;
        got.last           = out_tlast;
        got.attr_type      = out_tdata[7:0];
        got.value_length   = out_tdata[15:8];
        got.first_of_type  = out_tdata[16];
        got.value_word     = out_tdata[48:17];
        got.msg_code       = out_tdata[56:49];
        got.msg_ident      = out_tdata[64:57];
        got.acct_status    = out_tdata[96:65];
        got.nas_port_value = out_tdata[128:97];
        got.parse_status   = out_tdata[131:129];
        got.length_exceeds = out_tdata[132];
        if (parsed_results_q.size() == 0) begin
          if (mismatches < 10) $display("%0t: result beat with nothing pending", $time);
          mismatches++;
        end else begin
          want = parsed_results_q.pop_front();
          check_field("result_kind", want.kind, got.kind);
          check_field("last_result", want.last, got.last);
          check_field("attr_type", want.attr_type, got.attr_type);
          check_field("value_length", want.value_length, got.value_length);
          check_field("first_of_type", want.first_of_type, got.first_of_type);
          check_field("value_word", want.value_word, got.value_word);
          check_field("msg_code", want.msg_code, got.msg_code);
          check_field("msg_ident", want.msg_ident, got.msg_ident);
          check_field("acct_status", want.acct_status, got.acct_status);
          check_field("nas_port_value", want.nas_port_value, got.nas_port_value);
          check_field("parse_status", want.parse_status, got.parse_status);
          check_field("length_exceeds_payload", want.length_exceeds, got.length_exceeds);
        end
      end
    end
    backlog = parsed_results_q.size();
  end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

// Top of the parser bench: clock, reset, payload stimulus and the output-side
// backpressure. All prediction and comparison lives in radius_result_checker.
module testbench;
  import rap_pkg::*;

  // about 620 bytes in all; even if each waits the longest sender gap and causes
  // two beats behind the longest stalls, this limit is ample
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_BYTES = 150;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [7:0]             in_tdata;
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;

  int check_fails;
  int check_pending;
  int cycle_count = 0;
  int bytes_sent  = 0;

  // sender pacing: burst packets run back to back
  bit tx_burst = 1'b0;
  // receiver pacing, reselected every few dozen beats
  bit rx_burst = 1'b0;

  // packet under construction, one entry per payload byte
  logic [7:0] pkt_bytes[$];

  radius_attribute_parser i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  radius_result_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .fail_count    (check_fails),
    .pending_count (check_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Packet assembly helpers
  // ---------------------------------------------------------------------------

  // 20-byte header: code, identifier, length (network order), random authenticator
  task automatic put_header(input logic [7:0] code, input logic [7:0] ident,
                            input logic [15:0] hlen);
    pkt_bytes.push_back(code);
    pkt_bytes.push_back(ident);
    pkt_bytes.push_back(hlen[15:8]);
    pkt_bytes.push_back(hlen[7:0]);
    repeat (16) pkt_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // type, length and (length - 2) random value bytes; a length under two
  // leaves just the two attribute header bytes
  task automatic put_attr(input logic [7:0] atype, input logic [7:0] alen);
    pkt_bytes.push_back(atype);
    pkt_bytes.push_back(alen);
    if (alen >= ATTR_HDR_LEN) repeat (alen - ATTR_HDR_LEN) pkt_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  function automatic void patch_length(input logic [15:0] hlen);
    if (pkt_bytes.size() >= 4) begin
      pkt_bytes[2] = hlen[15:8];
      pkt_bytes[3] = hlen[7:0];
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Beat drivers; entered and left at a falling edge
  // ---------------------------------------------------------------------------

  task automatic send_byte(input logic [7:0] b, input logic eop);
    int gap;
    gap = $urandom_range(0, 16);
    if (tx_burst) gap = 0;
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tlast  = eop;
    // beat taken at the rising edge where tready is seen high
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_packet();
    tx_burst = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < pkt_bytes.size(); i++) send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
    pkt_bytes.delete();
  endtask

  // hold the input idle until the checker has seen every predicted beat
  task automatic drain();
    in_tvalid = 1'b0;
    while (check_pending != 0) @(negedge clk);
  endtask

  // Mostly well-formed packets with random content: valid code, a few TLVs
  // biased toward NAS-Port / Acct-Status-Type and repeats, then an optional
  // cut or trailing junk. The rest is raw noise.
  task automatic build_random_packet();
    int         pick;
    int         len_pick;
    int         nattr;
    logic [7:0] code;
    logic [7:0] atype;
    logic [7:0] alen;
    if ($urandom_range(0, 99) < 80) begin
      pick = $urandom_range(0, 5);
      code = (pick == 5) ? CODE_ACCESS_CHAL : CODE_ACCESS_REQ + 8'(pick);
      put_header(code, 8'($urandom_range(0, 255)), 16'd0);
      nattr = $urandom_range(0, 6);
      repeat (nattr) begin
        pick = $urandom_range(0, 9);
        if (pick < 3) atype = ATTR_NAS_PORT;
        else if (pick < 6) atype = ATTR_ACCT_STATUS;
        else if (pick == 6) atype = 8'($urandom_range(0, 3));
        else atype = 8'($urandom_range(0, 255));
        len_pick = $urandom_range(0, 19);
        if (len_pick == 0) alen = 8'($urandom_range(0, 1));        // below two
        else if (len_pick == 1) alen = 8'($urandom_range(2, 255)); // anything up to max
        else if (len_pick < 5) alen = ATTR_HDR_LEN;                // empty value
        else alen = 8'($urandom_range(3, 10));
        put_attr(atype, alen);
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        // cut anywhere, header included
        len_pick = $urandom_range(1, pkt_bytes.size());
        while (pkt_bytes.size() > len_pick) void'(pkt_bytes.pop_back());
      end else if (pick == 1) begin
        repeat ($urandom_range(1, 3)) pkt_bytes.push_back(8'($urandom_range(0, 255)));
      end
      // header length: exact, a little long, no longer than the payload, or arbitrary
      pick = $urandom_range(0, 3);
      if (pick == 0) patch_length(16'(pkt_bytes.size()));
      else if (pick == 1) patch_length(16'(pkt_bytes.size() + $urandom_range(1, 3)));
      else if (pick == 2) patch_length(16'($urandom_range(0, pkt_bytes.size())));
      else patch_length(16'($urandom_range(0, 65535)));
    end else begin
      repeat ($urandom_range(1, 40)) pkt_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall before each beat, with calm stretches
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    int rx_beats;
    out_tready = 1'b0;
    rx_beats   = 0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      stall = $urandom_range(0, 16);
      if (rx_burst) stall = 0;
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
      rx_beats++;
      if (rx_beats % 40 == 0) rx_burst = ($urandom_range(0, 2) == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and verdict
  // ---------------------------------------------------------------------------
  initial begin
    int random_start;
    int pkt_count;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    rst_n     = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // lone code byte: short header
    pkt_bytes.push_back(CODE_ACCESS_REQ);
    send_packet();

    // header missing its final byte: still short
    put_header(CODE_ACCT_RESP, 8'h00, 16'd19);
    void'(pkt_bytes.pop_back());
    send_packet();

    // header alone, ending exactly on its last byte
    put_header(CODE_ACCESS_CHAL, 8'hA5, 16'd20);
    send_packet();

    // code just past the accepted range; TLVs after it must be ignored,
    // header length beyond the payload
    put_header(CODE_ACCT_RESP + 8'd1, 8'h5A, 16'hFFFF);
    put_attr(ATTR_NAS_PORT, 8'd6);
    send_packet();

    // clean packet: repeated NAS-Port (first one kept), Acct-Status-Type
    // overwritten by an empty value then a one-byte value, type 0 and 255,
    // a value longer than four bytes and the largest attribute length
    put_header(CODE_ACCESS_REQ, 8'hFF, 16'd0);
    put_attr(ATTR_NAS_PORT, 8'd6);
    put_attr(ATTR_NAS_PORT, 8'd6);
    put_attr(ATTR_ACCT_STATUS, 8'd6);
    put_attr(ATTR_ACCT_STATUS, ATTR_HDR_LEN);
    put_attr(8'h00, ATTR_HDR_LEN);
    put_attr(8'hFF, 8'd12);
    put_attr(ATTR_ACCT_STATUS, 8'd3);
    put_attr(8'd26, 8'd255);
    patch_length(16'(pkt_bytes.size()));
    send_packet();

    // attribute length of one stops parsing; trailing bytes swallowed
    put_header(CODE_ACCESS_REQ + 8'd1, 8'h01, 16'd24);
    put_attr(8'd1, 8'd1);
    pkt_bytes.push_back(ATTR_NAS_PORT);
    pkt_bytes.push_back(8'd6);
    send_packet();

    // payload ends right after a type byte
    put_header(CODE_ACCESS_REQ + 8'd2, 8'h02, 16'd40);
    put_attr(8'd7, 8'd4);
    pkt_bytes.push_back(8'd8);
    send_packet();

    // payload ends inside a value
    put_header(CODE_ACCESS_REQ + 8'd3, 8'h03, 16'd30);
    put_attr(8'd9, 8'd10);
    repeat (7) void'(pkt_bytes.pop_back());
    send_packet();

    // let every pending beat drain before the random traffic starts
    drain();

    // random traffic, draining completely every eighth packet
    random_start = bytes_sent;
    pkt_count    = 0;
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      build_random_packet();
      send_packet();
      pkt_count++;
      if (pkt_count % 8 == 0) drain();
    end

    in_tvalid = 1'b0;
    while (check_pending != 0) @(negedge clk);
    // results trail the input through the queue and output register; leave room for strays
    repeat (8) @(negedge clk);
    if (check_fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
